// ===== sv/cmbt_pkg.sv =====
// Shared types and constants for the cell median background threshold block.
package cmbt_pkg;

  localparam int DATA_W    = 16;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EDGE_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 2'd1;

  // Buffer write request from the front to the pixel store
  typedef struct packed {
    logic              en;
    logic              bank;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } wr_req_t;

  // Bank handed back once its last pixel has been read
  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

  // One finished cell waiting to be drained
  typedef struct packed {
    logic                     bank;
    logic signed [DATA_W-1:0] thresh;
    logic [IDX_W-1:0]         last_idx;
  } job_t;

endpackage

// ===== sv/cmbt_front.sv =====
// Front end: loads cell pixels, keeps a sorted row of the lowest ones, forms the threshold.
module cmbt_front import cmbt_pkg::*; #(
  parameter int MAX_CELL = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_ready,
  input  logic [DATA_W-1:0]    pix,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output wr_req_t              wr,
  output logic                 job_valid,
  input  logic                 job_ready,
  output job_t                 job,
  input  rel_t                 rel
);

  localparam int DEPTH = MAX_CELL * MAX_CELL;
  localparam int SR    = (DEPTH - 1) / 2 + 1;
  localparam logic [3:0] SIZE_RST = (MAX_CELL < 8) ? 4'(MAX_CELL) : 4'd8;

  logic [3:0]               esize;
  logic signed [DATA_W-1:0] offset;
  logic [CNT_W-1:0]         fill;
  logic                     bank;
  logic                     fin;
  logic [1:0]               busy;
  logic signed [DATA_W-1:0] srt [SR];
  logic [SR-1:0]            sv;

  logic signed [DATA_W-1:0] srt_next [SR];
  logic signed [DATA_W-1:0] srt_prev [SR];
  logic [SR-1:0]            sv_next;
  logic [SR-1:0]            le;
  logic [SR-1:0]            le_prev;
  logic [1:0]               busy_next;
  logic signed [DATA_W-1:0] med;
  logic [7:0]               nprod;
  logic [CNT_W-1:0]         ncell;
  logic [CNT_W-1:0]         fill_inc;
  logic [3:0]               cfg_size;
  logic                     accept;

  assign accept    = pix_valid && pix_ready;
  assign pix_ready = !fin && !busy[bank];
  assign nprod     = 8'(esize) * 8'(esize);
  assign ncell     = nprod[CNT_W-1:0];
  assign fill_inc  = fill + 1'b1;

  // Clamp the written edge length into 1..MAX_CELL
  always_comb begin
    if (cfg_data[3:0] == 4'd0) begin
      cfg_size = 4'd1;
    end else if (cfg_data[3:0] > 4'(MAX_CELL)) begin
      cfg_size = 4'(MAX_CELL);
    end else begin
      cfg_size = cfg_data[3:0];
    end
  end

  // Insert the new pixel into the sorted row; the largest entry drops off the end
  always_comb begin
    srt_prev[0] = signed'(pix);
    for (int j = 1; j < SR; j++) begin
      srt_prev[j] = srt[j-1];
    end
    for (int j = 0; j < SR; j++) begin
      le[j] = sv[j] && (srt[j] <= signed'(pix));
    end
    le_prev = (le << 1) | SR'(1);
    sv_next = (sv << 1) | SR'(1);
    for (int j = 0; j < SR; j++) begin
      if (le[j]) begin
        srt_next[j] = srt[j];
      end else if (le_prev[j]) begin
        srt_next[j] = signed'(pix);
      end else begin
        srt_next[j] = srt_prev[j];
      end
    end
  end

  // Lower median sits at rank (n-1)/2 of the row
  always_comb begin
    med = srt[0];
    for (int e = 1; e <= MAX_CELL; e++) begin
      if (esize == 4'(e)) begin
        med = srt[(e * e - 1) / 2];
      end
    end
  end

  // Release a drained bank, claim the bank just queued
  always_comb begin
    busy_next = busy;
    if (rel.en) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (fin && job_ready) begin
      busy_next[bank] = 1'b1;
    end
  end

  assign wr.en   = accept;
  assign wr.bank = bank;
  assign wr.idx  = fill[IDX_W-1:0];
  assign wr.data = pix;

  assign job_valid    = fin;
  assign job.bank     = bank;
  assign job.thresh   = med + offset;
  assign job.last_idx = IDX_W'(ncell - 1'b1);

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < SR; j++) begin
        srt[j] <= srt_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esize  <= SIZE_RST;
      offset <= '0;
      fill   <= '0;
      bank   <= 1'b0;
      fin    <= 1'b0;
      busy   <= '0;
      sv     <= '0;
    end else begin
      busy <= busy_next;
      if (accept) begin
        sv   <= sv_next;
        fill <= fill_inc;
        if (fill_inc == ncell) begin
          fin <= 1'b1;
        end
      end
      if (fin && job_ready) begin
        bank <= !bank;
        fill <= '0;
        sv   <= '0;
        fin  <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_EDGE_LEN: begin
            esize <= cfg_size;
            fill  <= '0;
            sv    <= '0;
          end
          REG_OFFSET: begin
            offset <= signed'(cfg_data);
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== sv/cmbt_queue.sv =====
// Two-entry queue of finished cells between the front and the back.
module cmbt_queue import cmbt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = slot[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/cmbt_back.sv =====
// Back end: two-bank pixel store, drains a finished cell and applies the threshold.
module cmbt_back import cmbt_pkg::*; #(
  parameter int MAX_CELL = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  wr_req_t           wr,
  input  logic              job_valid,
  output logic              job_ready,
  input  job_t              job,
  output rel_t              rel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_pixel,
  output logic              out_last
);

  localparam int DEPTH = MAX_CELL * MAX_CELL;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0]        mem [2][DEPTH];

  logic                     act;
  logic                     bank;
  logic signed [DATA_W-1:0] thresh;
  logic [IDX_W-1:0]         cnt;
  logic [IDX_W-1:0]         lst;

  logic                     rd_pend;
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] rd_thresh;
  logic                     rd_last;

  logic                     load;
  logic                     issue;
  logic                     at_end;

  assign job_ready = !act;
  assign load      = rd_pend && (!out_valid || out_ready);
  assign issue     = act && (!rd_pend || load);
  assign at_end    = (cnt == lst);

  assign rel.en   = issue && at_end;
  assign rel.bank = bank;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.bank][wr.idx[AW-1:0]] <= wr.data;
    end
    if (issue) begin
      rd_data   <= signed'(mem[bank][cnt[AW-1:0]]);
      rd_thresh <= thresh;
      rd_last   <= at_end;
    end
    if (load) begin
      out_pixel <= (rd_data > rd_thresh) ? rd_data : '0;
      out_last  <= rd_last;
    end
    if (job_valid && job_ready) begin
      bank   <= job.bank;
      thresh <= job.thresh;
      lst    <= job.last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act       <= 1'b0;
      cnt       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        act <= 1'b1;
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + 1'b1;
        if (at_end) begin
          act <= 1'b0;
        end
      end
      if (issue) begin
        rd_pend <= 1'b1;
      end else if (load) begin
        rd_pend <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/cell_median_background_threshold.sv =====
// Top level of the cell median background threshold block.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata[15:0] pixel (signed)
//  m_axis   | out       | tdata[15:0] out_pixel (signed), tlast = last_of_cell
//  cfg      | in        | cfg_index: 0 edge length, 1 threshold offset; cfg_data
//
// Pixels load at one per cycle while s_axis_tready is high. After a cell's last
// pixel the median is taken from the sorted row and the cell is queued. The store
// has two banks: one cell loads while the other drains; s_axis stalls while a cell
// waits to be queued and while both banks are held. Results leave at one per cycle
// while m_axis_tready is high, via a read register and an output register.
// Reset clears control state; the store is not cleared.
module cell_median_background_threshold import cmbt_pkg::*; #(
  parameter int MAX_CELL = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,   // [15:0] pixel
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata,   // [15:0] out_pixel
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  wr_req_t wr;
  rel_t    rel;
  logic    fq_valid;
  logic    fq_ready;
  job_t    fq_job;
  logic    qb_valid;
  logic    qb_ready;
  job_t    qb_job;

  assign cfg_ready = 1'b1;

  cmbt_front #(
    .MAX_CELL (MAX_CELL)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (s_axis_tvalid),
    .pix_ready (s_axis_tready),
    .pix       (s_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr        (wr),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job),
    .rel       (rel)
  );

  cmbt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  cmbt_back #(
    .MAX_CELL (MAX_CELL)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .rel       (rel),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pixel (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== test/tb_cell_median_background_threshold.sv =====
// Self-checking testbench for the cell median background threshold block.
`timescale 1ns / 100ps

module tb_cell_median_background_threshold import cmbt_pkg::*; ();

  localparam int CELL_MAX        = 8;
  localparam int EDGE_LEN_RESET  = 8;
  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int IDLE_PCT        = 33;
  localparam int SETTLE_CYCLES   = 16;
  localparam int DRAIN_CYCLES    = 40;
  localparam int QUIET_LIMIT     = 2000;
  localparam int PIXEL_TARGET    = 480;

  // Indexes the block does not decode; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  typedef enum int {PIX_FULL, PIX_NEAR_ZERO, PIX_EXTREME, PIX_REPEAT} pix_style_t;

  // Tracks the registers and the partial cell, and holds the thresholded
  // pixels still owed by the block.
  class cell_threshold_predictor;
    logic [3:0]               size_reg;
    logic signed [DATA_W-1:0] offset_reg;
    logic signed [DATA_W-1:0] cell_px[$];
    logic signed [DATA_W-1:0] want_px[$];
    bit                       want_last[$];
    int                       errors;
    int                       checked;

    function new();
      size_reg   = 4'(EDGE_LEN_RESET);
      offset_reg = '0;
      errors     = 0;
      checked    = 0;
    endfunction

    function int cell_pixels();
      int e;
      e = int'(size_reg);
      if (e == 0) e = 1;
      else if (e > CELL_MAX) e = CELL_MAX;
      return e * e;
    endfunction

    function int outstanding();
      return want_px.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_EDGE_LEN: begin
          size_reg = val[3:0];
          // any size write drops the partial cell
          cell_px.delete();
        end
        REG_OFFSET: begin
          offset_reg = val;
        end
        default: ;
      endcase
    endfunction

    // Lower median by insertion sort of the held cell
    function logic signed [DATA_W-1:0] lower_median();
      logic signed [DATA_W-1:0] srt [CELL_MAX*CELL_MAX];
      logic signed [DATA_W-1:0] v;
      int n;
      int j;
      n = cell_px.size();
      for (int i = 0; i < n; i++) begin
        v = cell_px[i];
        j = i;
        while (j > 0 && srt[j-1] > v) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = v;
      end
      return srt[(n - 1) / 2];
    endfunction

    function void note_pixel(logic [DATA_W-1:0] px);
      logic signed [DATA_W-1:0] thr;
      logic signed [DATA_W-1:0] p;
      int n;
      n = cell_pixels();
      if (cell_px.size() >= n) cell_px.delete();
      cell_px.push_back(px);
      if (cell_px.size() < n) return;
      // threshold wraps to the pixel width
      thr = lower_median() + offset_reg;
      for (int i = 0; i < n; i++) begin
        p = cell_px[i];
        want_px.push_back((p > thr) ? p : '0);
        want_last.push_back(i == n - 1);
      end
      cell_px.delete();
    endfunction

    function void check_result(logic [DATA_W-1:0] got, logic got_last);
      logic signed [DATA_W-1:0] exp_px;
      bit                       exp_last;
      if (want_px.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: out_pixel %0d last %0b",
                 $time, $signed(got), got_last);
        return;
      end
      exp_px   = want_px.pop_front();
      exp_last = want_last.pop_front();
      checked++;
      if (got !== exp_px) begin
        errors++;
        $display("%0t: out_pixel mismatch: expected %0d, got %0d",
                 $time, exp_px, $signed(got));
      end
      if (got_last !== exp_last) begin
        errors++;
        $display("%0t: last_of_cell mismatch: expected %0b, got %0b",
                 $time, exp_last, got_last);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata = '0;   // [15:0] pixel
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;        // [15:0] out_pixel
  logic                 m_axis_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  cell_threshold_predictor sb;
  bit          stall_free = 1'b0;
  int          n_pixels = 0;
  int          n_writes = 0;
  int unsigned quiet_cycles = 0;

  cell_median_background_threshold #(.MAX_CELL(CELL_MAX)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Result side: check on each accepted request, then pick the next ready
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= stall_free || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drive_pixel(input logic [DATA_W-1:0] px);
    // unless stall_free, idle at random so about a third of the cycles are idle
    if (!stall_free) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_pixel(px);
    n_pixels++;
  endtask

  // Hold the pixel stream, let the block drain and settle, then write
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    n_writes++;
  endtask

  function automatic logic [DATA_W-1:0] pick_pixel(pix_style_t style);
    logic [DATA_W-1:0] v;
    case (style)
      PIX_NEAR_ZERO: begin
        v = 16'($urandom_range(0, 40));
        v = v - 16'd20;
      end
      PIX_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       v = 16'h8000;
          1:       v = 16'h7FFF;
          2:       v = 16'hFFFF;
          3:       v = 16'h0001;
          default: v = 16'h0000;
        endcase
      end
      PIX_REPEAT: begin
        // few distinct values, so the median lands on duplicates
        v = 16'($urandom_range(0, 3));
        v = v * 16'd1000 - 16'd1500;
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] pick_offset();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = 16'h0000;
      1:       v = 16'h7FFF;
      2:       v = 16'h8000;
      3, 4:    begin
        v = 16'($urandom_range(0, 200));
        v = v - 16'd100;
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_pixels(input int count, input pix_style_t style);
    for (int i = 0; i < count; i++) drive_pixel(pick_pixel(style));
  endtask

  initial begin
    int         r;
    int         edge_code;
    int         cells;
    int         n;
    logic [DATA_W-1:0] hi_bits;
    pix_style_t style;

    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Partial cell at reset settings: offset write keeps it, size write drops it
    drive_pixel(16'h7FFF);
    drive_pixel(16'h8000);
    drive_pixel(16'h0001);
    program_reg(REG_OFFSET, 16'h0005);
    program_reg(REG_EDGE_LEN, 16'd2);
    program_reg(REG_OFFSET, 16'h0000);
    drive_pixel(16'h8000);
    drive_pixel(16'h7FFF);
    drive_pixel(16'h0000);
    drive_pixel(16'hFFFF);

    // Edge code zero acts as one; a pixel equal to the threshold is zeroed
    program_reg(REG_EDGE_LEN, 16'd0);
    drive_pixel(16'd5);
    program_reg(REG_OFFSET, 16'hFFFF);
    drive_pixel(16'd5);

    // Threshold wrap in both directions
    program_reg(REG_OFFSET, 16'h7FFF);
    drive_pixel(16'h0001);
    drive_pixel(16'h8000);
    program_reg(REG_OFFSET, 16'h8000);
    drive_pixel(16'hFFFF);
    drive_pixel(16'h8000);

    // Offset changed part-way through a cell applies to that cell
    program_reg(REG_EDGE_LEN, 16'd2);
    program_reg(REG_OFFSET, 16'h0000);
    drive_pixel(16'd10);
    drive_pixel(16'd20);
    program_reg(REG_OFFSET, 16'd100);
    drive_pixel(16'd300);
    drive_pixel(16'd400);

    // Rewriting the same edge length still drops the partial cell
    drive_pixel(16'd7);
    program_reg(REG_EDGE_LEN, 16'd2);
    send_pixels(4, PIX_FULL);

    while (n_pixels < PIXEL_TARGET) begin
      stall_free = (n_pixels >= 200 && n_pixels < 300);

      if ($urandom_range(0, 99) < 80) begin
        r = $urandom_range(0, 99);
        if (r < 81) edge_code = $urandom_range(1, 4);
        else if (r < 89) edge_code = $urandom_range(5, 7);
        else if (r < 93) edge_code = CELL_MAX;
        else if (r < 97) edge_code = 0;
        else edge_code = $urandom_range(CELL_MAX + 1, 15);
        hi_bits = 16'($urandom);
        program_reg(REG_EDGE_LEN, {hi_bits[DATA_W-1:4], 4'(edge_code)});
      end
      if ($urandom_range(0, 99) < 70) program_reg(REG_OFFSET, pick_offset());
      if ($urandom_range(0, 99) < 5)
        program_reg($urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3, 16'($urandom));

      n     = sb.cell_pixels();
      cells = (n > 16) ? 1 : $urandom_range(1, 3);
      for (int c = 0; c < cells; c++) begin
        style = pix_style_t'($urandom_range(0, 3));
        send_pixels(n, style);
      end
      // leave a partial cell behind now and then
      if (n > 1 && $urandom_range(0, 99) < 25)
        send_pixels($urandom_range(1, n - 1), PIX_FULL);
    end

    s_axis_tvalid <= 1'b0;
    stall_free = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixels, checked %0d thresholded pixels, made %0d register writes",
             n_pixels, sb.checked, n_writes);
    $display("Covered edge lengths 1 to %0d, wrapped thresholds and writes inside a cell",
             CELL_MAX);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
